@@ hdl/mac_header_field_classifier_macros.svh @@
// Assertion helpers for the checker file.
`ifndef MAC_HEADER_FIELD_CLASSIFIER_MACROS_SVH
`define MAC_HEADER_FIELD_CLASSIFIER_MACROS_SVH

// Clocked check, quiet while reset is high.
`define MHFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs across reset.
`define MHFC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mhfc_pkg.sv @@
`default_nettype none
package mhfc_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 1023;

  // byte classes
  localparam logic [3:0] CLS_FCF    = 4'd0;
  localparam logic [3:0] CLS_SEQ    = 4'd1;
  localparam logic [3:0] CLS_DPAN   = 4'd2;
  localparam logic [3:0] CLS_DADDR  = 4'd3;
  localparam logic [3:0] CLS_SPAN   = 4'd4;
  localparam logic [3:0] CLS_SADDR  = 4'd5;
  localparam logic [3:0] CLS_SECCTL = 4'd6;
  localparam logic [3:0] CLS_CNT    = 4'd7;
  localparam logic [3:0] CLS_KSRC   = 4'd8;
  localparam logic [3:0] CLS_KIDX   = 4'd9;
  localparam logic [3:0] CLS_HIE    = 4'd10;
  localparam logic [3:0] CLS_PIE    = 4'd11;
  localparam logic [3:0] CLS_PAY    = 4'd12;
  localparam logic [3:0] CLS_MIC    = 4'd13;
  localparam logic [3:0] CLS_OPQ    = 4'd14;

  // frame status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_TYPE      = 3'd2;
  localparam logic [2:0] ST_MODE      = 3'd3;
  localparam logic [2:0] ST_VERSION   = 3'd4;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  localparam logic [4:0] MIC_LIMIT = 5'd16;

  typedef struct packed {
    logic [3:0] warnings;
    logic [4:0] mic_bytes;
    logic [9:0] payload_ie_count;
    logic [9:0] header_ie_count;
    logic [2:0] status;
    logic       frame_done;
    logic [7:0] byte_value;
    logic [3:0] byte_class;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage
`default_nettype wire

@@ hdl/mac_header_field_classifier.sv @@
// A byte's results are registered into the result queue and offered on m_tvalid.
// Throughput: one byte per cycle while s_tready is high; an IE header's second
// byte yields two results, drained one per cycle (while m_tready) via a four-entry queue.
// Reset: synchronous, active high; clears the parse state and empties the queue.
`default_nettype none
module mac_header_field_classifier
  import mhfc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // data_byte[7:0], frame_length[17:8], zero fill
  input  wire logic        s_tuser,  // first_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // byte_value, status, header_ie_count,
                                     // payload_ie_count, mic_bytes, warnings
  output logic [3:0]       m_tuser,  // byte_class
  output logic             m_tlast   // frame_done
);

  push_t push;
  res_t  head;
  logic  room;

  // Take a byte whenever the queue can hold the worst case of two results.
  assign s_tready = room;

  mhfc_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid && s_tready),
    .data_byte   (s_tdata[7:0]),
    .first_byte  (s_tuser),
    .frame_length(s_tdata[17:8]),
    .push        (push)
  );

  // Hold results until the downstream side takes them.
  mhfc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tvalid && m_tready),
    .head      (head),
    .head_valid(m_tvalid),
    .room      (room)
  );

  assign m_tdata = {head.warnings, head.mic_bytes, head.payload_ie_count,
                    head.header_ie_count, head.status, head.byte_value};
  assign m_tuser = head.byte_class;
  assign m_tlast = head.frame_done;

endmodule
`default_nettype wire

@@ hdl/mhfc_parser.sv @@
`default_nettype none
module mhfc_parser
  import mhfc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic [9:0] frame_length,
  output push_t           push
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int WW = PW + 12;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [PW-1:0] len;
    logic [15:0]   cw;
    logic [3:0]    cur;
    logic [3:0]    fbl;
    logic [1:0]    pan;
    logic [7:0]    sc;
    logic [9:0]    hie_n;
    logic [9:0]    pie_n;
    logic [10:0]   ie_left;
    logic [7:0]    held;
    logic [2:0]    status;
    logic [3:0]    warn;
  } ps_t;

  ps_t st, st_next;

  function automatic logic secured_f(ps_t s);
    return s.cw[3] && (s.cw[13:12] != 2'd0);
  endfunction

  function automatic logic [4:0] mic_raw_f(ps_t s);
    logic [4:0] m;
    m = 5'd0;
    if (secured_f(s)) begin
      case (s.sc[1:0])
        2'd0:    m = 5'd0;
        2'd1:    m = 5'd4;
        2'd2:    m = 5'd8;
        default: m = 5'd16;
      endcase
    end
    return m;
  endfunction

  function automatic logic [4:0] mic_eff_f(ps_t s);
    return s.warn[3] ? 5'd0 : mic_raw_f(s);
  endfunction

  function automatic logic [3:0] addr_len_f(logic [1:0] m);
    return (m == 2'd2) ? 4'd2 : ((m == 2'd3) ? 4'd8 : 4'd0);
  endfunction

  // {ok, src pan present, dst pan present}
  function automatic logic [2:0] pan_f(ps_t s);
    logic [1:0] d, sm;
    logic       comp, dp, sp, ok;
    d = s.cw[11:10];
    sm = s.cw[15:14];
    comp = s.cw[6];
    dp = 1'b0;
    sp = 1'b0;
    ok = 1'b1;
    if (s.cw[13:12] < 2'd2) begin
      if (d != 2'd0 && sm != 2'd0) begin
        dp = 1'b1;
        sp = !comp;
      end else if (comp) begin
        ok = 1'b0;
      end else if (d != 2'd0) begin
        dp = 1'b1;
      end else if (sm != 2'd0) begin
        sp = 1'b1;
      end
    end else if (d == 2'd0 && sm == 2'd0) begin
      dp = comp;
    end else if (sm == 2'd0) begin
      dp = !comp;
    end else if (d == 2'd0) begin
      sp = !comp;
    end else if (d == 2'd3 && sm == 2'd3) begin
      dp = !comp;
    end else if (d == 2'd2 || sm == 2'd2) begin
      dp = 1'b1;
      sp = !comp;
    end else begin
      ok = 1'b0;
    end
    return {ok, sp, dp};
  endfunction

  // Walk forward from field fld to the first one that takes bytes.
  function automatic ps_t enter_f(ps_t s_in, logic [3:0] fld_in, logic [PW-1:0] nxt);
    ps_t         s;
    logic [3:0]  fld, n;
    logic [PW-1:0] rem;
    logic [1:0]  km;
    logic [2:0]  pr;
    logic        done, cont;
    logic [WW-1:0] lim;
    s = s_in;
    fld = fld_in;
    rem = (s.len > nxt) ? (s.len - nxt) : '0;
    done = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (!done) begin
        n = 4'd0;
        cont = 1'b0;
        km = s.sc[4:3];
        case (fld)
          CLS_SEQ:   n = s.cw[8] ? 4'd0 : 4'd1;
          CLS_DPAN: begin
            pr = pan_f(s);
            if (!pr[2]) begin
              s.cur = CLS_OPQ;
              s.status = ST_BAD_ADDR;
              done = 1'b1;
            end else begin
              s.pan = pr[1:0];
              n = pr[0] ? 4'd2 : 4'd0;
            end
          end
          CLS_DADDR: n = addr_len_f(s.cw[11:10]);
          CLS_SPAN:  n = s.pan[1] ? 4'd2 : 4'd0;
          CLS_SADDR: n = addr_len_f(s.cw[15:14]);
          CLS_SECCTL: begin
            if (!secured_f(s)) begin
              fld = CLS_HIE;
              cont = 1'b1;
            end else begin
              n = 4'd1;
            end
          end
          CLS_CNT:  n = (s.cw[13:12] == 2'd2 && s.sc[5]) ? 4'd0 : 4'd4;
          CLS_KSRC: n = (km == 2'd2) ? 4'd4 : ((km == 2'd3) ? 4'd8 : 4'd0);
          CLS_KIDX: n = (km != 2'd0) ? 4'd1 : 4'd0;
          CLS_HIE: begin
            if (s.cw[9]) begin
              s.cur = CLS_HIE;
              s.ie_left = '0;
              s.fbl = '0;
              lim = WW'(nxt) + WW'(2) + WW'(mic_raw_f(s));
              if (lim > WW'(s.len)) begin
                fld = CLS_PAY;
                cont = 1'b1;
              end else begin
                done = 1'b1;
              end
            end else begin
              fld = CLS_PAY;
              cont = 1'b1;
            end
          end
          default: begin
            if (PW'(mic_raw_f(s)) > rem) s.warn[3] = 1'b1;
            s.cur = CLS_PAY;
            done = 1'b1;
          end
        endcase
        if (!done && !cont) begin
          if (n == 4'd0) begin
            fld = fld + 4'd1;
          end else if (rem < PW'(n)) begin
            s.cur = CLS_OPQ;
            s.status = ST_TRUNCATED;
            done = 1'b1;
          end else begin
            s.cur = fld;
            s.fbl = n;
            done = 1'b1;
          end
        end
      end
    end
    return s;
  endfunction

  function automatic ps_t ie_boundary_f(ps_t s_in, logic [PW-1:0] nxt);
    ps_t s;
    logic [WW-1:0] lim;
    s = s_in;
    s.ie_left = '0;
    s.fbl = '0;
    lim = WW'(nxt) + WW'(2) + WW'(mic_raw_f(s));
    if (lim > WW'(s.len)) s = enter_f(s, CLS_PAY, nxt);
    return s;
  endfunction

  function automatic ps_t elem_end_f(ps_t s_in, logic [PW-1:0] nxt);
    ps_t s;
    s = s_in;
    if (s.cur == CLS_HIE) begin
      if (s.held == 8'h7e) begin
        s.cur = CLS_PIE;
        s = ie_boundary_f(s, nxt);
      end else if (s.held == 8'h7f) begin
        s = enter_f(s, CLS_PAY, nxt);
      end else begin
        s = ie_boundary_f(s, nxt);
      end
    end else if (s.held == 8'h0f) begin
      s = enter_f(s, CLS_PAY, nxt);
    end else begin
      s = ie_boundary_f(s, nxt);
    end
    return s;
  endfunction

  function automatic logic [3:0] pay_class_f(ps_t s, logic [PW-1:0] p);
    logic [PW-1:0] m;
    m = PW'(mic_eff_f(s));
    return (s.len >= m && p < s.len - m) ? CLS_PAY : CLS_MIC;
  endfunction

  function automatic res_t mk_f(ps_t s, logic [3:0] cls, logic [7:0] b, logic done);
    res_t r;
    r.byte_class = cls;
    r.byte_value = b;
    r.frame_done = done;
    r.status = s.status;
    r.header_ie_count = s.hie_n;
    r.payload_ie_count = s.pie_n;
    r.mic_bytes = (s.cur == CLS_PAY) ? mic_eff_f(s) : 5'd0;
    r.warnings = s.warn;
    return r;
  endfunction

  always_comb begin
    ps_t           s;
    logic [WW-1:0] lw, lim;
    logic [PW-1:0] p, nxt;
    logic [3:0]    cls;
    logic [15:0]   hdr;
    logic [7:0]    id, first;
    logic [10:0]   ln;
    logic          single;
    s = st;
    push.count = 2'd0;
    push.r0 = '0;
    push.r1 = '0;
    single = 1'b0;
    cls = CLS_OPQ;
    p = '0;
    nxt = '0;
    hdr = '0;
    id = '0;
    ln = '0;
    first = '0;
    lim = '0;
    lw = '0;
    if (first_byte) begin
      s = '0;
      lw = WW'(frame_length);
      if (lw == '0) lw = WW'(1);
      if (lw > WW'(MAX_FRAME_BYTES)) lw = WW'(MAX_FRAME_BYTES);
      s.len = lw[PW-1:0];
      s.fbl = 4'd2;
      if (lw < WW'(2)) s.status = ST_SHORT;
    end
    p = s.pos;
    if (p >= s.len) begin
      push.r0 = mk_f(s, CLS_OPQ, data_byte, 1'b0);
      push.count = 2'd1;
    end else begin
      nxt = p + PW'(1);
      s.pos = nxt;
      cls = s.cur;
      case (s.cur)
        CLS_FCF: begin
          if (p == '0) s.cw = {8'h00, data_byte};
          else s.cw[15:8] = s.cw[15:8] | data_byte;
          if (s.len < PW'(2)) begin
            s.cur = CLS_OPQ;
          end else if (p >= PW'(1)) begin
            if (s.cw[2:0] > 3'd3) begin
              s.cur = CLS_OPQ;
              s.status = ST_TYPE;
            end else if (s.cw[11:10] == 2'd1 || s.cw[15:14] == 2'd1) begin
              s.cur = CLS_OPQ;
              s.status = ST_MODE;
            end else if (s.cw[13:12] == 2'd3) begin
              s.cur = CLS_OPQ;
              s.status = ST_VERSION;
            end else begin
              if (s.cw[8] && s.cw[13:12] != 2'd2) s.warn[0] = 1'b1;
              s = enter_f(s, CLS_SEQ, nxt);
            end
          end
          single = 1'b1;
        end
        CLS_HIE, CLS_PIE: begin
          if (s.ie_left != '0) begin
            s.ie_left = s.ie_left - 11'd1;
            if (s.cur == CLS_HIE) s.hie_n = s.hie_n + 10'd1;
            else s.pie_n = s.pie_n + 10'd1;
            if (s.ie_left == '0) s = elem_end_f(s, nxt);
            single = 1'b1;
          end else if (s.fbl == 4'd0) begin
            s.held = data_byte;
            s.fbl = 4'd1;
          end else begin
            s.fbl = 4'd0;
            hdr = {data_byte, s.held};
            if (s.cur == CLS_HIE) begin
              id = hdr[14:7];
              ln = {4'd0, hdr[6:0]};
            end else begin
              id = {4'd0, hdr[14:11]};
              ln = hdr[10:0];
            end
            lim = WW'(p) + WW'(1) + WW'(ln) + WW'(mic_raw_f(s));
            if (lim > WW'(s.len)) begin
              if (s.cur == CLS_HIE) s.warn[1] = 1'b1;
              else s.warn[2] = 1'b1;
              s = enter_f(s, CLS_PAY, p - PW'(1));
              push.r0 = mk_f(s, pay_class_f(s, p - PW'(1)), s.held, 1'b0);
              push.r1 = mk_f(s, pay_class_f(s, p), data_byte, nxt == s.len);
            end else begin
              if (s.cur == CLS_HIE) s.hie_n = s.hie_n + 10'd2;
              else s.pie_n = s.pie_n + 10'd2;
              first = s.held;
              s.held = id;
              s.ie_left = ln;
              if (ln == '0) s = elem_end_f(s, nxt);
              push.r0 = mk_f(s, cls, first, 1'b0);
              push.r1 = mk_f(s, cls, data_byte, nxt == s.len);
            end
            push.count = 2'd2;
          end
        end
        CLS_PAY, CLS_MIC: begin
          cls = pay_class_f(s, p);
          single = 1'b1;
        end
        CLS_OPQ: single = 1'b1;
        default: begin
          if (s.cur == CLS_SECCTL) s.sc = data_byte;
          if (s.fbl != 4'd0) s.fbl = s.fbl - 4'd1;
          if (s.fbl == 4'd0) s = enter_f(s, s.cur + 4'd1, nxt);
          single = 1'b1;
        end
      endcase
      if (single) begin
        push.r0 = mk_f(s, cls, data_byte, nxt == s.len);
        push.count = 2'd1;
      end
    end
    if (!in_valid) push.count = 2'd0;
    st_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_valid) begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mhfc_outq.sv @@
`default_nettype none
module mhfc_outq
  import mhfc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output res_t       head,
  output logic       head_valid,
  output logic       room
);

  localparam int QD = 4;
  localparam int AW = $clog2(QD);

  res_t          q [QD];
  logic [AW-1:0] wr, rd;
  logic [AW:0]   cnt;

  assign head = q[rd];
  assign head_valid = (cnt != '0);
  // room for a two-result request
  assign room = (cnt <= (AW+1)'(QD - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) q[wr] <= push.r0;
    if (push.count == 2'd2) q[wr + AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      cnt <= '0;
    end else begin
      wr <= wr + AW'(push.count);
      if (pop) rd <= rd + AW'(1);
      cnt <= cnt + (AW+1)'(push.count) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hdl/mhfc_checker.sv @@
`default_nettype none
`include "mac_header_field_classifier_macros.svh"
module mhfc_checker
  import mhfc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [3:0]  m_tuser
);

  `MHFC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `MHFC_ASSERT_RST(a_reset, rst |=> !m_tvalid && s_tready, "queue not empty after reset")
  `MHFC_ASSERT(a_class, m_tvalid |-> m_tuser <= CLS_OPQ, "byte class out of range")
  `MHFC_ASSERT(a_mic, m_tvalid && m_tdata[35:31] != 5'd0 |-> m_tuser == CLS_PAY || m_tuser == CLS_MIC || m_tuser == CLS_HIE || m_tuser == CLS_PIE || m_tuser == CLS_OPQ || m_tdata[35:31] <= MIC_LIMIT, "mic length out of range")

endmodule

bind mac_header_field_classifier mhfc_checker u_mhfc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
`default_nettype wire
